[hdl/skf_pkg.sv]
package skf_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned GAIN_W   = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIV_STEPS = 17;
  localparam int unsigned CNT_W    = 5;

  localparam logic [VALUE_W-1:0] PROCESS_NOISE_RST = 32'd655;
  localparam logic [VALUE_W-1:0] MEASURE_NOISE_RST = 32'd65536;
  localparam logic [GAIN_W-1:0]  ONE_Q16           = 17'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 2'd1;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic gain;
    logic mul_est;
    logic mul_cov;
    logic commit;
  } skf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;
  } skf_sts_t;

endpackage

[hdl/skf_datapath.sv]
module skf_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [skf_pkg::VALUE_W-1:0]          cfg_data,
  input  logic signed [skf_pkg::SAMPLE_W-1:0]  in_measurement,
  input  skf_pkg::skf_cmd_t                    cmd,
  output skf_pkg::skf_sts_t                    sts,
  output logic signed [skf_pkg::VALUE_W-1:0]   out_estimate,
  output logic [skf_pkg::GAIN_W-1:0]           out_gain
);
  import skf_pkg::*;

  logic [VALUE_W-1:0]        process_noise_r;
  logic [VALUE_W-1:0]        measure_noise_r;
  logic signed [VALUE_W-1:0] est_r;
  logic [VALUE_W-1:0]        cov_r;

  logic signed [SAMPLE_W-1:0] sample_r;
  logic [VALUE_W-1:0]        p_mid_r;
  logic [VALUE_W:0]          denom_r;
  logic [VALUE_W+1:0]        rem_r;
  logic [GAIN_W-1:0]         quo_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [GAIN_W-1:0]         gain_r;
  logic signed [VALUE_W:0]   diff_r;
  logic signed [51:0]        prod_r;
  logic signed [VALUE_W-1:0] est_new_r;
  logic signed [VALUE_W-1:0] out_estimate_r;
  logic [GAIN_W-1:0]         out_gain_r;

  logic [VALUE_W:0]          pq_sum;
  logic [VALUE_W-1:0]        p_mid_nxt;
  logic [VALUE_W+1:0]        denom_ext;
  logic                      rem_ge;
  logic [VALUE_W+1:0]        rem_sub;
  logic [VALUE_W+1:0]        rem_nxt;
  logic signed [17:0]        mul_a;
  logic signed [33:0]        mul_b;
  logic signed [51:0]        mul_p;
  logic [GAIN_W-1:0]         one_minus_gain;

  // predict: covariance plus process noise, saturating
  assign pq_sum    = {1'b0, cov_r} + {1'b0, process_noise_r};
  assign p_mid_nxt = pq_sum[VALUE_W] ? '1 : pq_sum[VALUE_W-1:0];

  // restoring divider, one quotient bit per step
  assign denom_ext = {1'b0, denom_r};
  assign rem_ge    = (rem_r >= denom_ext);
  assign rem_sub   = rem_ge ? (rem_r - denom_ext) : rem_r;
  assign rem_nxt   = {rem_sub[VALUE_W:0], 1'b0};

  // one shared multiplier for the estimate and covariance updates
  assign one_minus_gain = ONE_Q16 - gain_r;
  always_comb begin
    if (cmd.mul_cov) begin
      mul_a = signed'({1'b0, one_minus_gain});
      mul_b = signed'({2'b00, p_mid_r});
    end else begin
      mul_a = signed'({1'b0, gain_r});
      mul_b = {diff_r[VALUE_W], diff_r};
    end
  end
  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      process_noise_r <= PROCESS_NOISE_RST;
      measure_noise_r <= MEASURE_NOISE_RST;
      est_r           <= '0;
      cov_r           <= '0;
      cnt_r           <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_PROCESS_NOISE) begin
          process_noise_r <= cfg_data;
        end else if (cfg_index == REG_MEASURE_NOISE) begin
          measure_noise_r <= cfg_data;
        end
      end
      if (cmd.load) begin
        cnt_r <= '0;
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.commit) begin
        est_r <= est_new_r;
        cov_r <= prod_r[47:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_measurement;
      p_mid_r  <= p_mid_nxt;
      denom_r  <= {1'b0, p_mid_nxt} + {1'b0, measure_noise_r};
      rem_r    <= {2'b00, p_mid_nxt};
      quo_r    <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[GAIN_W-2:0], rem_ge};
    end
    if (cmd.gain) begin
      // zero denominator gives zero gain
      gain_r <= (denom_r == '0) ? '0 : quo_r;
      diff_r <= signed'({sample_r[SAMPLE_W-1], sample_r, 16'h0000})
                - signed'({est_r[VALUE_W-1], est_r});
    end
    if (cmd.mul_est) begin
      prod_r <= mul_p;
    end
    if (cmd.mul_cov) begin
      // arithmetic shift rounds the correction toward minus infinity
      est_new_r <= est_r + prod_r[47:16];
      prod_r    <= mul_p;
    end
    if (cmd.commit) begin
      out_estimate_r <= est_new_r;
      out_gain_r     <= gain_r;
    end
  end

  assign sts.div_last = (cnt_r == CNT_W'(DIV_STEPS - 1));
  assign out_estimate = out_estimate_r;
  assign out_gain     = out_gain_r;

endmodule

[hdl/skf_ctrl.sv]
module skf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  skf_pkg::skf_sts_t sts,
  output skf_pkg::skf_cmd_t cmd
);
  import skf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_GAIN,
    S_MULX,
    S_MULP,
    S_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // result slot is free when empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_GAIN;
        end
      end
      S_GAIN: begin
        cmd.gain  = 1'b1;
        state_nxt = S_MULX;
      end
      S_MULX: begin
        cmd.mul_est = 1'b1;
        state_nxt   = S_MULP;
      end
      S_MULP: begin
        cmd.mul_cov = 1'b1;
        state_nxt   = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.commit ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid_r && out_stall))
    else $error("result overwritten while held");

  a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_COMMIT))
    else $error("result raised without commit");

  a_div_runs_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && !sts.div_last) |=> (state_r == S_DIV))
    else $error("divider left early");

endmodule

[hdl/scalar_kalman_filter_unit.sv]
// scalar kalman filter, Q16.16 estimate and covariance, Q0.16 gain
// input channel: in_valid/in_stall carry one signed 16-bit sample per beat
// result channel: out_valid/out_stall carry the new estimate and the gain used
// config port: cfg_we writes cfg_data to register cfg_index (0 process noise,
// 1 measurement noise); other indexes are ignored; write only while idle
// latency: out_valid rises 21 cycles after the input beat is taken
// throughput: one sample every 22 cycles, set by the restoring divider
// that forms the gain one quotient bit per cycle (17 cycles), followed by
// two passes through one shared multiplier and a commit cycle
// in_stall is high from the accepted beat until the result is committed
// a finished result sits in the output register while the next sample is
// taken; if out_stall holds it there, the next result waits in its final
// cycle and the held beat does not change
// reset (synchronous, rst_n low) clears estimate and covariance to zero,
// loads the noise registers with their defaults and empties the result slot
module scalar_kalman_filter_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [skf_pkg::VALUE_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [skf_pkg::SAMPLE_W-1:0]  in_measurement,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [skf_pkg::VALUE_W-1:0]   out_estimate,
  output logic [skf_pkg::GAIN_W-1:0]           out_gain
);
  import skf_pkg::*;

  skf_cmd_t cmd;
  skf_sts_t sts;

  skf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  skf_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_measurement (in_measurement),
    .cmd            (cmd),
    .sts            (sts),
    .out_estimate   (out_estimate),
    .out_gain       (out_gain)
  );

endmodule

[test/scalar_kalman_filter_unit_test.sv]
module scalar_kalman_filter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import skf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int LONG_HOLD   = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;

  typedef enum logic [2:0] {
    STEP_SAMPLE,
    STEP_WRITE,
    STEP_DRAIN,
    STEP_PACE,
    STEP_HOLD
  } step_kind_t;

  typedef struct packed {
    step_kind_t                   kind;
    logic [CFG_IDX_W-1:0]         idx;
    logic [VALUE_W-1:0]           data;
    logic signed [SAMPLE_W-1:0]   meas;
    logic [6:0]                   idle_pct;
    logic [6:0]                   stall_pct;
  } stim_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] estimate;
    logic [GAIN_W-1:0]         gain;
  } result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [VALUE_W-1:0]          cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [SAMPLE_W-1:0]  in_measurement = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [VALUE_W-1:0]   out_estimate;
  logic [GAIN_W-1:0]           out_gain;

  scalar_kalman_filter_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_measurement (in_measurement),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_estimate   (out_estimate),
    .out_gain       (out_gain)
  );

  stim_t   stim_q[$];
  result_t estimate_q[$];

  int         fail_count = 0;
  int         samples_sent = 0;
  int         results_seen = 0;
  int         idle_pct = 0;
  logic [6:0] stall_pct = '0;
  logic       hold_toggle = 1'b0;

  // filter state and noise registers as the block should hold them
  logic signed [VALUE_W-1:0] model_est;
  logic [VALUE_W-1:0]        model_cov;
  logic [VALUE_W-1:0]        model_q;
  logic [VALUE_W-1:0]        model_r;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("mismatch at %0t ns: %s", $realtime, msg);
  endtask

  function automatic result_t kalman_step(input logic signed [SAMPLE_W-1:0] meas);
    logic [32:0]        p_pred;
    logic [63:0]        denom;
    logic [63:0]        gain_w;
    logic [63:0]        p_next;
    logic signed [63:0] meas_w;
    logic signed [63:0] est_w;
    logic signed [63:0] diff;
    logic signed [63:0] corr;
    result_t            res;
    p_pred = {1'b0, model_cov} + {1'b0, model_q};
    if (p_pred[32]) p_pred = 33'h0_FFFF_FFFF;
    denom = 64'(p_pred) + 64'(model_r);
    if (denom == 64'd0) gain_w = 64'd0;
    else gain_w = (64'(p_pred) << 16) / denom;
    if (gain_w > 64'(ONE_Q16)) gain_w = 64'(ONE_Q16);
    meas_w = meas;
    est_w = model_est;
    diff = (meas_w <<< 16) - est_w;
    corr = $signed(gain_w) * diff;
    // arithmetic shift gives the floor of the correction
    est_w = est_w + (corr >>> 16);
    p_next = ((64'(ONE_Q16) - gain_w) * 64'(p_pred)) >> 16;
    model_est = est_w[VALUE_W-1:0];
    model_cov = p_next[VALUE_W-1:0];
    res.estimate = model_est;
    res.gain = gain_w[GAIN_W-1:0];
    return res;
  endfunction

  task automatic add_sample(input logic signed [SAMPLE_W-1:0] meas);
    stim_t s;
    s = '0;
    s.kind = STEP_SAMPLE;
    s.meas = meas;
    stim_q.push_back(s);
  endtask

  task automatic add_drain();
    stim_t s;
    s = '0;
    s.kind = STEP_DRAIN;
    stim_q.push_back(s);
  endtask

  // registers only change once the block has gone quiet
  task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
    stim_t s;
    add_drain();
    s = '0;
    s.kind = STEP_WRITE;
    s.idx = idx;
    s.data = data;
    stim_q.push_back(s);
  endtask

  task automatic add_pace(input int idle, input int stall);
    stim_t s;
    s = '0;
    s.kind = STEP_PACE;
    s.idle_pct = idle[6:0];
    s.stall_pct = stall[6:0];
    stim_q.push_back(s);
  endtask

  task automatic add_hold();
    stim_t s;
    s = '0;
    s.kind = STEP_HOLD;
    stim_q.push_back(s);
  endtask

  function automatic logic [VALUE_W-1:0] pick_noise();
    case ($urandom_range(5))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 262144);
      3: return $urandom;
      4: return $urandom_range(0, 1023);
      default: return 32'h1_0000 << $urandom_range(0, 15);
    endcase
  endfunction

  always @(posedge clk) begin : drive_samples
    logic  nxt_valid;
    logic  nxt_we;
    stim_t head;
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      nxt_we = 1'b0;
      if (in_valid && !in_stall) begin
        samples_sent++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && stim_q.size() > 0) begin
        head = stim_q[0];
        case (head.kind)
          STEP_SAMPLE: begin
            if ($urandom_range(99) >= idle_pct) begin
              in_measurement <= head.meas;
              nxt_valid = 1'b1;
              void'(stim_q.pop_front());
            end
          end
          STEP_WRITE: begin
            nxt_we = 1'b1;
            cfg_index <= head.idx;
            cfg_data <= head.data;
            void'(stim_q.pop_front());
          end
          STEP_DRAIN: begin
            if (samples_sent == results_seen) void'(stim_q.pop_front());
          end
          STEP_PACE: begin
            idle_pct = head.idle_pct;
            stall_pct <= head.stall_pct;
            void'(stim_q.pop_front());
          end
          STEP_HOLD: begin
            hold_toggle <= ~hold_toggle;
            void'(stim_q.pop_front());
          end
          default: void'(stim_q.pop_front());
        endcase
      end
      in_valid <= nxt_valid;
      cfg_we <= nxt_we;
    end
  end

  always @(posedge clk) begin : watch_results
    result_t want;
    logic    hold_seen;
    int      hold_left;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_seen = hold_toggle;
      hold_left = 0;
      model_est = '0;
      model_cov = '0;
      model_q = PROCESS_NOISE_RST;
      model_r = MEASURE_NOISE_RST;
    end else begin
      // a result never leaves on the edge that takes its own sample
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (estimate_q.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected, estimate %0d",
                                    out_estimate));
        end else begin
          want = estimate_q.pop_front();
          if (out_estimate !== want.estimate)
            report_mismatch($sformatf("estimate %0d, expected %0d",
                                      out_estimate, want.estimate));
          if (out_gain !== want.gain)
            report_mismatch($sformatf("gain %0d, expected %0d", out_gain, want.gain));
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_PROCESS_NOISE) model_q = cfg_data;
        else if (cfg_index == REG_MEASURE_NOISE) model_r = cfg_data;
      end
      if (in_valid && !in_stall) estimate_q.push_back(kalman_step(in_measurement));
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet;
    if (!rst_n) begin
      quiet = 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin : run_test
    int level;
    int meas;
    int ph;
    int n;
    add_pace(0, 0);
    // reset noise values, sample extremes and alternating bit patterns
    add_sample(16'sd32767);
    add_sample(-16'sd32768);
    add_sample(16'sd0);
    add_sample(-16'sd1);
    add_sample(16'sd1);
    add_sample(16'sh5555);
    add_sample(16'shAAAA);
    // covariance saturates, no measurement noise: gain of one
    add_write(REG_PROCESS_NOISE, 32'hFFFF_FFFF);
    add_write(REG_MEASURE_NOISE, 32'h0);
    add_sample(16'sd100);
    add_sample(-16'sd100);
    // largest measurement noise
    add_write(REG_MEASURE_NOISE, 32'hFFFF_FFFF);
    add_sample(16'sd32767);
    add_sample(-16'sd32768);
    // both noises zero: covariance collapses, then the denominator is zero
    add_write(REG_PROCESS_NOISE, 32'h0);
    add_write(REG_MEASURE_NOISE, 32'h0);
    add_sample(16'sd5);
    add_sample(-16'sd7);
    add_sample(16'sd3);
    // writes to unused indexes leave both registers alone
    add_write(REG_SPARE_A, $urandom);
    add_write(REG_SPARE_B, $urandom);
    add_sample(16'sd1000);
    add_sample(-16'sd1234);

    for (ph = 0; ph < 8; ph++) begin
      add_write(REG_PROCESS_NOISE, pick_noise());
      add_write(REG_MEASURE_NOISE, pick_noise());
      case (ph % 4)
        0: add_pace(0, 0);
        1: add_pace(66, 0);
        2: add_pace(0, 66);
        default: add_pace(13, 13);
      endcase
      // receiver holds off while samples keep coming
      if (ph % 4 == 0) add_hold();
      level = $urandom_range(0, 65535) - 32768;
      for (n = 0; n < 142; n++) begin
        if (n % 20 == 0) level = level + $urandom_range(0, 2000) - 1000;
        case ($urandom_range(9))
          0: meas = $urandom;
          1: meas = $urandom_range(1) ? 32767 : -32768;
          default: meas = level + $urandom_range(0, 64) - 32;
        endcase
        if (n == 70) add_drain();
        add_sample(meas[SAMPLE_W-1:0]);
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (stim_q.size() != 0 || in_valid || samples_sent != results_seen)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (estimate_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", estimate_q.size()));
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
hdl/skf_pkg.sv
hdl/skf_datapath.sv
hdl/skf_ctrl.sv
hdl/scalar_kalman_filter_unit.sv
test/scalar_kalman_filter_unit_test.sv
